@@ hdl/slte_pkg.sv @@
// Shared types, codes and sizes for the sprite list tile expander.
package slte_pkg;

  // List storage
  localparam int LIST_DEPTH = 256;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Request modes
  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_APPEND  = 2'd1;
  localparam logic [1:0] MODE_DISPLAY = 2'd2;

  // Sprite size codes; the reserved code is stored but draws nothing
  localparam logic [1:0] SIZE_8X8      = 2'd0;
  localparam logic [1:0] SIZE_8X16     = 2'd1;
  localparam logic [1:0] SIZE_16X16    = 2'd2;
  localparam logic [1:0] SIZE_RESERVED = 2'd3;

  typedef enum logic [1:0] {
    ST_DRAW     = 2'd0,
    ST_ACCEPT   = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic {
    FE_IDLE,
    FE_READ
  } front_state_t;

  // One stored sprite, 44 bits
  typedef struct packed {
    logic               flip_v;
    logic               flip_h;
    logic [1:0]         palette_sel;
    logic [1:0]         size_code;
    logic [15:0]        tile_base;
    logic signed [10:0] sprite_y;
    logic signed [10:0] sprite_x;
  } sprite_t;

  // Work handed from front to back
  typedef struct packed {
    logic    is_sprite;
    status_t status;
    logic    done;
    sprite_t spr;
  } job_t;

endpackage

@@ hdl/slte_if.sv @@
// Request and response channel interfaces of the sprite list tile expander.
interface slte_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [10:0] sprite_x;
  logic signed [10:0] sprite_y;
  logic [15:0]        tile_base;
  logic [1:0]         size_code;
  logic [1:0]         palette_sel;
  logic               flip_h;
  logic               flip_v;

  modport source (output valid, mode, sprite_x, sprite_y, tile_base, size_code,
                  palette_sel, flip_h, flip_v, input ready);
  modport sink (input valid, mode, sprite_x, sprite_y, tile_base, size_code,
                palette_sel, flip_h, flip_v, output ready);
endinterface

interface slte_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [11:0] draw_x;
  logic signed [11:0] draw_y;
  logic [15:0]        draw_tile;
  logic [2:0]         draw_palette;
  logic               draw_flip_h;
  logic               draw_flip_v;
  logic               last_of_run;
  logic               frame_done;

  modport source (output valid, status, draw_x, draw_y, draw_tile, draw_palette,
                  draw_flip_h, draw_flip_v, last_of_run, frame_done, input ready);
  modport sink (input valid, status, draw_x, draw_y, draw_tile, draw_palette,
                draw_flip_h, draw_flip_v, last_of_run, frame_done, output ready);
endinterface

@@ hdl/slte_queue.sv @@
// Short job queue that decouples the list front end from the tile expander.
module slte_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  slte_pkg::job_t push_job,
  output logic          full,
  output logic          head_valid,
  output slte_pkg::job_t head_job,
  input  logic          pop
);
  import slte_pkg::*;

  job_t                slots [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  fill;

  assign full       = (fill == Q_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = slots[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ hdl/slte_front.sv @@
// List front end: takes requests, keeps the sprite list and walk state.
module slte_front (
  input  logic           clk,
  input  logic           rst,
  slte_req_if.sink       req,
  output logic           push,
  output slte_pkg::job_t push_job,
  input  logic           queue_full
);
  import slte_pkg::*;

  front_state_t      state;
  front_state_t      state_next;
  sprite_t           mem [LIST_DEPTH];
  sprite_t           rdata;
  logic              rd_done;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_pos;
  logic              reverse;

  logic              accept;
  logic              list_empty;
  logic              list_full;
  logic [CNT_W-1:0]  rev_pos;
  logic [CNT_W-1:0]  rd_pos_inc;
  logic [IDX_W-1:0]  rd_idx;
  sprite_t           wr_spr;

  assign accept     = req.valid && req.ready;
  assign list_empty = (count == '0) || (rd_pos >= count);
  assign list_full  = (count >= CNT_W'(LIST_DEPTH));
  assign rev_pos    = count - 1'b1 - rd_pos;
  assign rd_pos_inc = rd_pos + 1'b1;
  assign rd_idx     = reverse ? rev_pos[IDX_W-1:0] : rd_pos[IDX_W-1:0];

  assign wr_spr = '{flip_v: req.flip_v, flip_h: req.flip_h,
                    palette_sel: req.palette_sel, size_code: req.size_code,
                    tile_base: req.tile_base, sprite_y: req.sprite_y,
                    sprite_x: req.sprite_x};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      FE_IDLE: begin
        if (accept && req.mode == MODE_DISPLAY && !list_empty) begin
          state_next = FE_READ;
        end
      end
      FE_READ: begin
        state_next = FE_IDLE;
      end
      default: begin
        state_next = FE_IDLE;
      end
    endcase
  end

  // Outputs: handshake and queue push
  always_comb begin
    req.ready = 1'b0;
    push      = 1'b0;
    push_job  = '{is_sprite: 1'b0, status: ST_ACCEPT, done: 1'b0, spr: '0};
    unique case (state)
      FE_IDLE: begin
        req.ready = !queue_full;
        if (accept) begin
          case (req.mode)
            MODE_CLEAR: begin
              push = 1'b1;
            end
            MODE_APPEND: begin
              push = 1'b1;
              push_job.status = list_full ? ST_OVERFLOW : ST_ACCEPT;
            end
            MODE_DISPLAY: begin
              // Empty walk answers at once; a real sprite waits for the read
              if (list_empty) begin
                push = 1'b1;
                push_job.status = ST_NONE;
                push_job.done   = 1'b1;
              end
            end
            default: begin
              push = 1'b0;
            end
          endcase
        end
      end
      FE_READ: begin
        push     = 1'b1;
        push_job = '{is_sprite: 1'b1, status: ST_DRAW, done: rd_done, spr: rdata};
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Sprite store: write on append, registered read on display
  always_ff @(posedge clk) begin
    if (accept && req.mode == MODE_APPEND && !list_full) begin
      mem[count[IDX_W-1:0]] <= wr_spr;
    end
    if (accept && req.mode == MODE_DISPLAY && !list_empty) begin
      rdata   <= mem[rd_idx];
      rd_done <= (rd_pos_inc >= count);
    end
  end

  // List count and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= FE_IDLE;
      count   <= '0;
      rd_pos  <= '0;
      reverse <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (req.mode)
          MODE_CLEAR: begin
            count  <= '0;
            rd_pos <= '0;
          end
          MODE_APPEND: begin
            if (!list_full) begin
              count <= count + 1'b1;
            end
          end
          MODE_DISPLAY: begin
            // Toggle direction at the end of a walk or on an empty list
            if (list_empty || rd_pos_inc >= count) begin
              rd_pos  <= '0;
              reverse <= !reverse;
            end else begin
              rd_pos <= rd_pos_inc;
            end
          end
          default: begin
            rd_pos <= rd_pos;
          end
        endcase
      end
    end
  end

endmodule

@@ hdl/slte_back.sv @@
// Tile expander: turns a queued job into results, one per cycle unless stalled.
module slte_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  slte_pkg::job_t job,
  output logic           pop,
  slte_rsp_if.source     rsp
);
  import slte_pkg::*;

  logic [1:0]         step;
  logic [1:0]         last_step;
  logic               load;
  logic               is_draw;
  logic               col;
  logic               row;
  logic signed [11:0] x_ext;
  logic signed [11:0] y_ext;
  logic signed [11:0] x_off;
  logic [15:0]        col_tile;
  logic               tile_inc;
  status_t            res_status;

  // Number of results for the job, less one
  always_comb begin
    last_step = 2'd0;
    if (job.is_sprite) begin
      case (job.spr.size_code)
        SIZE_8X16:  last_step = 2'd1;
        SIZE_16X16: last_step = 2'd3;
        default:    last_step = 2'd0;
      endcase
    end
  end

  assign load    = job_valid && (!rsp.valid || rsp.ready);
  assign pop     = load && (step == last_step);
  assign is_draw = job.is_sprite && (job.spr.size_code != SIZE_RESERVED);
  assign col     = step[1];
  assign row     = step[0];
  assign x_ext   = {job.spr.sprite_x[10], job.spr.sprite_x};
  assign y_ext   = {job.spr.sprite_y[10], job.spr.sprite_y} + 12'sd1;

  // Column offset from the sprite centre
  always_comb begin
    case (job.spr.size_code)
      SIZE_8X16:  x_off = -12'sd4;
      SIZE_16X16: x_off = col ? 12'sd0 : -12'sd8;
      default:    x_off = 12'sd0;
    endcase
  end

  // Right column of a wide sprite uses the next tile block; mirror swaps columns
  assign col_tile = (job.spr.size_code == SIZE_16X16 && ((col == 1'b0) == job.spr.flip_h))
                    ? job.spr.tile_base + 16'd16 : job.spr.tile_base;
  assign tile_inc = (job.spr.size_code != SIZE_8X8) && (job.spr.flip_v ^ row);

  assign res_status = job.is_sprite ? (is_draw ? ST_DRAW : ST_NONE) : job.status;

  // Advance through the job's results
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 2'd0;
    end else if (load) begin
      step <= pop ? 2'd0 : step + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status      <= res_status;
      rsp.last_of_run <= (step == last_step);
      rsp.frame_done  <= job.done;
      if (is_draw) begin
        rsp.draw_x       <= x_ext + x_off;
        rsp.draw_y       <= row ? y_ext + 12'sd8 : y_ext;
        rsp.draw_tile    <= col_tile + {15'd0, tile_inc};
        rsp.draw_palette <= {1'b1, job.spr.palette_sel};
        rsp.draw_flip_h  <= job.spr.flip_h;
        rsp.draw_flip_v  <= job.spr.flip_v;
      end else begin
        rsp.draw_x       <= '0;
        rsp.draw_y       <= '0;
        rsp.draw_tile    <= '0;
        rsp.draw_palette <= '0;
        rsp.draw_flip_h  <= 1'b0;
        rsp.draw_flip_v  <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/sprite_list_tile_expander.sv @@
// Sprite list tile expander top level: front end, job queue and tile expander.
//
// Keeps a list of up to 256 sprites for one frame. A clear or append request
// answers with one result; a display request reads the next sprite of the walk
// and expands it into one, two or four 8x8 tile draws (one result and no draw
// for the reserved size). A clear, an append or a display that finds nothing
// to show is taken in the idle state; a display of a listed sprite also passes
// a read state, where the request port is not ready, as the sprite store has a
// registered read port. The expander emits one result per cycle unless the
// response port stalls, so 16x16 sprites, at four results, set the display rate.
// A four-entry job queue lets requests carry on while the response is stalled.
module sprite_list_tile_expander (
  input  logic       clk,
  input  logic       rst,
  slte_req_if.sink   req,
  slte_rsp_if.source rsp
);
  import slte_pkg::*;

  logic push;
  job_t push_job;
  logic queue_full;
  logic head_valid;
  job_t head_job;
  logic pop;

  slte_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push       (push),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  slte_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  slte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule
